// ----- src/tbwg_pkg.sv -----
// ----------------------------------------------------------------------------
// tbwg_pkg: shared types and constants for the table waveform generator
// Field widths, register indexes, wave kinds, sequencer states and the
// status bundle of the iterative phase divider.
// ----------------------------------------------------------------------------
package tbwg_pkg;

  // Field widths
  localparam int KIND_W     = 2;
  localparam int LEN_W      = 13;
  localparam int IDX_W      = 12;
  localparam int REP_W      = 20;
  localparam int AMP_W      = 18;
  localparam int CPV_W      = 24;
  localparam int CODE_W     = 12;
  localparam int CH_W       = 2;
  localparam int PHASE_W    = 16;
  localparam int VAL_W      = 16;
  localparam int ROMV_W     = 15;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 24;

  // Shared multiplier operand widths
  localparam int MUL_A_W = 25;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Table length bound
  localparam int MAX_TABLE = 4096;
  localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(2);
  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'((MAX_TABLE < 4096) ? MAX_TABLE : 4096);

  // Sine ROM
  localparam int SINE_ROM_DEPTH_DEF = 256;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Voltage limit in 1/4096 V units
  localparam int VOLT_LIMIT = 32768;

  // Reset values of the configuration registers
  localparam logic [KIND_W-1:0]       RST_KIND = '0;
  localparam logic [LEN_W-1:0]        RST_LEN  = LEN_W'(64);
  localparam logic [REP_W-1:0]        RST_REP  = REP_W'(1);
  localparam logic signed [AMP_W-1:0] RST_AMP  = AMP_W'(4096);
  localparam logic signed [AMP_W-1:0] RST_OFF  = '0;
  localparam logic [CPV_W-1:0]        RST_CPV  = CPV_W'(14909440);
  localparam logic [CODE_W-1:0]       RST_ZERO = CODE_W'(2048);
  localparam logic [CH_W-1:0]         RST_CHAN = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KIND    = 8'd0,
    REG_LENGTH  = 8'd1,
    REG_REPEAT  = 8'd2,
    REG_AMP     = 8'd3,
    REG_OFFSET  = 8'd4,
    REG_CPV     = 8'd5,
    REG_ZERO    = 8'd6,
    REG_CHANNEL = 8'd7
  } cfg_reg_t;

  typedef enum logic [KIND_W-1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_TRI    = 2'd1,
    WAVE_SAW    = 2'd2,
    WAVE_SQUARE = 2'd3
  } wave_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ROM,
    ST_WAVE,
    ST_MUL1,
    ST_VOLT,
    ST_MUL2,
    ST_CODE
  } seq_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ----- src/tbwg_if.sv -----
// ----------------------------------------------------------------------------
// tbwg_if: channel interfaces of the table waveform generator
// Sample tick input, DAC code result and configuration write channels.
// ----------------------------------------------------------------------------
interface tbwg_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface tbwg_out_if;
  logic                          valid;
  logic                          ready;
  logic [tbwg_pkg::CODE_W-1:0]   dac_code;
  logic [tbwg_pkg::CH_W-1:0]     channel;
  logic [tbwg_pkg::IDX_W-1:0]    sample_index;
  logic                          period_end;

  modport source (output valid, output dac_code, output channel, output sample_index,
                  output period_end, input ready);
  modport sink   (input valid, input dac_code, input channel, input sample_index,
                  input period_end, output ready);
endinterface

interface tbwg_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tbwg_pkg::CFG_IDX_W-1:0]  index;
  logic [tbwg_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/tbwg_divider.sv -----
// ----------------------------------------------------------------------------
// tbwg_divider: iterative phase divider
// Forms floor(index * 2^16 / length) one quotient bit per cycle with a
// shared shift-and-subtract step. Requires index below length.
// ----------------------------------------------------------------------------
module tbwg_divider (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [tbwg_pkg::IDX_W-1:0]       dividend,
  input  logic [tbwg_pkg::LEN_W-1:0]       divisor,
  output logic [tbwg_pkg::PHASE_W-1:0]     quotient,
  output tbwg_pkg::div_status_t            status
);

  localparam int CntW = $clog2(tbwg_pkg::PHASE_W);

  logic [tbwg_pkg::LEN_W-1:0]   rem_r;
  logic [tbwg_pkg::LEN_W-1:0]   dvs_r;
  logic [tbwg_pkg::PHASE_W-1:0] quo_r;
  logic [CntW-1:0]              cnt_r;
  logic                         busy_r;

  logic [tbwg_pkg::LEN_W:0]     rem2;
  logic                         ge;
  logic [tbwg_pkg::LEN_W-1:0]   rem_nxt;

  // One restoring step: double the remainder, subtract when it fits
  always_comb begin
    rem2    = {rem_r, 1'b0};
    ge      = rem2 >= {1'b0, dvs_r};
    rem_nxt = ge ? tbwg_pkg::LEN_W'(rem2 - {1'b0, dvs_r}) : rem2[tbwg_pkg::LEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CntW'(tbwg_pkg::PHASE_W - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= tbwg_pkg::LEN_W'(dividend);
      dvs_r <= divisor;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[tbwg_pkg::PHASE_W-2:0], ge};
    end
  end

  assign quotient    = quo_r;
  assign status.busy = busy_r;
  assign status.done = busy_r && (cnt_r == '0);

endmodule

// ----- src/tbwg_sine_rom.sv -----
// ----------------------------------------------------------------------------
// tbwg_sine_rom: quarter-wave sine table
// Entries 0..DEPTH of sin(pi/2 * k/DEPTH) in Q15, built at elaboration from
// a fixed-point Taylor series; registered read.
// ----------------------------------------------------------------------------
module tbwg_sine_rom #(
  parameter int DEPTH = tbwg_pkg::SINE_ROM_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic [$clog2(DEPTH+1)-1:0]       addr,
  output logic [tbwg_pkg::ROMV_W-1:0]      data_r
);

  logic [tbwg_pkg::ROMV_W-1:0] rom_w [DEPTH+1];

  for (genvar k = 0; k <= DEPTH; k++) begin : g_entry
    localparam longint unsigned X  = (64'(k) * tbwg_pkg::HALF_PI_Q30) / DEPTH;
    localparam longint unsigned X2 = (X * X) >> 30;
    localparam longint unsigned T1 = ((X * X2) >> 30) / 6;
    localparam longint unsigned T2 = ((T1 * X2) >> 30) / 20;
    localparam longint unsigned T3 = ((T2 * X2) >> 30) / 42;
    localparam longint unsigned T4 = ((T3 * X2) >> 30) / 72;
    localparam longint unsigned T5 = ((T4 * X2) >> 30) / 110;
    localparam longint SUM  = longint'(X) - longint'(T1) + longint'(T2)
                            - longint'(T3) + longint'(T4) - longint'(T5);
    localparam longint SUMC = (SUM < 0) ? 64'sd0 : SUM;
    localparam longint RND  = (SUMC + 64'sd16384) >>> 15;
    localparam longint SAT  = (RND > 64'sd32767) ? 64'sd32767 : RND;
    assign rom_w[k] = tbwg_pkg::ROMV_W'(SAT);
  end

  always_ff @(posedge clk) begin
    data_r <= rom_w[addr];
  end

endmodule

// ----- src/tbwg_mul.sv -----
// ----------------------------------------------------------------------------
// tbwg_mul: shared signed multiplier
// One registered signed product, reused for amplitude scaling and for the
// volt-to-code conversion.
// ----------------------------------------------------------------------------
module tbwg_mul (
  input  logic                                    clk,
  input  logic                                    en,
  input  logic signed [tbwg_pkg::MUL_A_W-1:0]     op_a,
  input  logic signed [tbwg_pkg::MUL_B_W-1:0]     op_b,
  output logic signed [tbwg_pkg::MUL_P_W-1:0]     prod_r
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= tbwg_pkg::MUL_P_W'(op_a) * tbwg_pkg::MUL_P_W'(op_b);
    end
  end

endmodule

// ----- src/table_waveform_generator_top.sv -----
// ----------------------------------------------------------------------------
// table_waveform_generator_top: lookup-table waveform generator
// One DAC code per sample tick: phase division, sine/triangle/sawtooth/
// square shaping, amplitude and offset, +/-8 V clamp, DAC code conversion,
// with each sample held for a programmable number of ticks.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake      Payload
//  --------  ---  -------------  ---------------------------------------------
//  in_chan   in   valid / ready  restart
//  out_chan  out  valid / ready  dac_code, channel, sample_index, period_end
//  cfg_chan  in   valid / ready  index (register number), data
//
//  An input transfer runs through the phase divider, a ROM read, the wave
//  step, a pass through the shared multiplier, the voltage step, a second
//  multiplier pass and the code step into the output register. Most of the
//  time goes to the 16-step shift-and-subtract phase divider.
//  in_chan.ready is high only while the sequencer is idle; the finished
//  code waits in the output register, so a new tick is taken while it stalls.
//  A stalled output holds the sequencer at its last step until taken.
//  rst_n is synchronous; it resets the control and configuration registers,
//  while the data path registers are not reset. cfg_chan.ready is always high.
// ----------------------------------------------------------------------------
module table_waveform_generator_top #(
  parameter int SINE_ROM_DEPTH = tbwg_pkg::SINE_ROM_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  tbwg_in_if.sink     in_chan,
  tbwg_out_if.source  out_chan,
  tbwg_cfg_if.sink    cfg_chan
);

  localparam int RomAw = $clog2(SINE_ROM_DEPTH + 1);
  localparam int KMulW = tbwg_pkg::ROMV_W + RomAw;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [tbwg_pkg::KIND_W-1:0]       kind_r;
  logic [tbwg_pkg::LEN_W-1:0]        len_cfg_r;
  logic [tbwg_pkg::REP_W-1:0]        rep_cfg_r;
  logic signed [tbwg_pkg::AMP_W-1:0] amp_r;
  logic signed [tbwg_pkg::AMP_W-1:0] off_r;
  logic [tbwg_pkg::CPV_W-1:0]        cpv_r;
  logic [tbwg_pkg::CODE_W-1:0]       zero_r;
  logic [tbwg_pkg::CH_W-1:0]         chan_r;

  assign cfg_chan.ready = 1'b1;

  // Drop writes to indexes beyond the register list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r    <= tbwg_pkg::RST_KIND;
      len_cfg_r <= tbwg_pkg::RST_LEN;
      rep_cfg_r <= tbwg_pkg::RST_REP;
      amp_r     <= tbwg_pkg::RST_AMP;
      off_r     <= tbwg_pkg::RST_OFF;
      cpv_r     <= tbwg_pkg::RST_CPV;
      zero_r    <= tbwg_pkg::RST_ZERO;
      chan_r    <= tbwg_pkg::RST_CHAN;
    end else if (cfg_chan.valid) begin
      unique case (tbwg_pkg::cfg_reg_t'(cfg_chan.index))
        tbwg_pkg::REG_KIND:    kind_r    <= cfg_chan.data[tbwg_pkg::KIND_W-1:0];
        tbwg_pkg::REG_LENGTH:  len_cfg_r <= cfg_chan.data[tbwg_pkg::LEN_W-1:0];
        tbwg_pkg::REG_REPEAT:  rep_cfg_r <= cfg_chan.data[tbwg_pkg::REP_W-1:0];
        tbwg_pkg::REG_AMP:     amp_r     <= $signed(cfg_chan.data[tbwg_pkg::AMP_W-1:0]);
        tbwg_pkg::REG_OFFSET:  off_r     <= $signed(cfg_chan.data[tbwg_pkg::AMP_W-1:0]);
        tbwg_pkg::REG_CPV:     cpv_r     <= cfg_chan.data[tbwg_pkg::CPV_W-1:0];
        tbwg_pkg::REG_ZERO:    zero_r    <= cfg_chan.data[tbwg_pkg::CODE_W-1:0];
        tbwg_pkg::REG_CHANNEL: chan_r    <= cfg_chan.data[tbwg_pkg::CH_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  tbwg_pkg::seq_state_t  state_r, state_nxt;
  tbwg_pkg::div_status_t div_st;

  logic out_valid_r;
  logic out_free;
  logic accept;
  logic mul_en;
  logic mul_sel_code;
  logic val_ld;
  logic volt_ld;
  logic out_ld;

  assign out_free = !out_valid_r || out_chan.ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tbwg_pkg::ST_IDLE: if (in_chan.valid) state_nxt = tbwg_pkg::ST_DIV;
      tbwg_pkg::ST_DIV:  if (div_st.done)   state_nxt = tbwg_pkg::ST_ROM;
      tbwg_pkg::ST_ROM:  state_nxt = tbwg_pkg::ST_WAVE;
      tbwg_pkg::ST_WAVE: state_nxt = tbwg_pkg::ST_MUL1;
      tbwg_pkg::ST_MUL1: state_nxt = tbwg_pkg::ST_VOLT;
      tbwg_pkg::ST_VOLT: state_nxt = tbwg_pkg::ST_MUL2;
      tbwg_pkg::ST_MUL2: state_nxt = tbwg_pkg::ST_CODE;
      tbwg_pkg::ST_CODE: if (out_free) state_nxt = tbwg_pkg::ST_IDLE;
      default:           state_nxt = tbwg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_chan.ready = 1'b0;
    mul_en        = 1'b0;
    mul_sel_code  = 1'b0;
    val_ld        = 1'b0;
    volt_ld       = 1'b0;
    out_ld        = 1'b0;
    unique case (state_r)
      tbwg_pkg::ST_IDLE: in_chan.ready = 1'b1;
      tbwg_pkg::ST_WAVE: val_ld  = 1'b1;
      tbwg_pkg::ST_MUL1: mul_en  = 1'b1;
      tbwg_pkg::ST_VOLT: volt_ld = 1'b1;
      tbwg_pkg::ST_MUL2: begin
        mul_en       = 1'b1;
        mul_sel_code = 1'b1;
      end
      tbwg_pkg::ST_CODE: out_ld = out_free;
      default: ;
    endcase
  end

  assign accept = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tbwg_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Tick bookkeeping: index, hold counter, wrap flag (settled at transfer)
  // --------------------------------------------------------------------------
  logic [tbwg_pkg::IDX_W-1:0] phase_r, phase_nxt;
  logic [tbwg_pkg::REP_W-1:0] rep_left_r, rep_left_nxt;
  logic [tbwg_pkg::LEN_W-1:0] len_eff;
  logic [tbwg_pkg::REP_W-1:0] rep_eff;
  logic [tbwg_pkg::IDX_W-1:0] idx_acc;
  logic [tbwg_pkg::REP_W-1:0] rep_now;
  logic [tbwg_pkg::LEN_W-1:0] idx_inc;
  logic                       wrap_nxt;

  logic [tbwg_pkg::IDX_W-1:0] idx_r;
  logic [tbwg_pkg::LEN_W-1:0] len_r;
  logic                       wrap_r;

  always_comb begin
    // Clamp the length into the supported range, treat a zero hold as one
    if (len_cfg_r < tbwg_pkg::LEN_MIN) begin
      len_eff = tbwg_pkg::LEN_MIN;
    end else if (len_cfg_r > tbwg_pkg::LEN_CAP) begin
      len_eff = tbwg_pkg::LEN_CAP;
    end else begin
      len_eff = len_cfg_r;
    end
    rep_eff = (rep_cfg_r == '0) ? tbwg_pkg::REP_W'(1) : rep_cfg_r;

    // Restart, or an index left stale by a shorter table, starts at zero
    if (in_chan.restart || ({1'b0, phase_r} >= len_eff)) begin
      idx_acc = '0;
    end else begin
      idx_acc = phase_r;
    end
    rep_now = in_chan.restart ? rep_eff : rep_left_r;
    idx_inc = {1'b0, idx_acc} + 1'b1;

    wrap_nxt = 1'b0;
    if (rep_now > tbwg_pkg::REP_W'(1)) begin
      rep_left_nxt = rep_now - 1'b1;
      phase_nxt    = idx_acc;
    end else begin
      rep_left_nxt = rep_eff;
      if (idx_inc >= len_eff) begin
        phase_nxt = '0;
        wrap_nxt  = 1'b1;
      end else begin
        phase_nxt = idx_inc[tbwg_pkg::IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= '0;
      rep_left_r <= tbwg_pkg::REP_W'(1);
    end else if (accept) begin
      phase_r    <= phase_nxt;
      rep_left_r <= rep_left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r  <= idx_acc;
      len_r  <= len_eff;
      wrap_r <= wrap_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Phase p = floor(index * 2^16 / length)
  // --------------------------------------------------------------------------
  logic [tbwg_pkg::PHASE_W-1:0] phase_p;

  tbwg_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .dividend (idx_acc),
    .divisor  (len_eff),
    .quotient (phase_p),
    .status   (div_st)
  );

  // --------------------------------------------------------------------------
  // Quarter-wave sine lookup: fold the phase into the first quadrant
  // --------------------------------------------------------------------------
  logic [1:0]                  quad;
  logic [13:0]                 frac;
  logic [tbwg_pkg::ROMV_W-1:0] pos;
  logic [KMulW-1:0]            kmul;
  logic [RomAw-1:0]            rom_addr;
  logic [tbwg_pkg::ROMV_W-1:0] rom_data;

  always_comb begin
    quad     = phase_p[tbwg_pkg::PHASE_W-1 -: 2];
    frac     = phase_p[13:0];
    pos      = quad[0] ? tbwg_pkg::ROMV_W'(15'd16384 - {1'b0, frac}) : {1'b0, frac};
    kmul     = KMulW'(pos) * KMulW'(SINE_ROM_DEPTH);
    rom_addr = RomAw'(kmul >> 14);
  end

  tbwg_sine_rom #(
    .DEPTH (SINE_ROM_DEPTH)
  ) u_rom (
    .clk    (clk),
    .addr   (rom_addr),
    .data_r (rom_data)
  );

  // --------------------------------------------------------------------------
  // Wave value in Q1.15
  // --------------------------------------------------------------------------
  logic signed [tbwg_pkg::VAL_W-1:0] value_r;
  logic signed [tbwg_pkg::VAL_W-1:0] value_w;
  logic signed [18:0]                tri_w;

  always_comb begin
    // Triangle rises over the first half of the period, falls over the second
    if (phase_p[tbwg_pkg::PHASE_W-1]) begin
      tri_w = 19'sd98304 - $signed({2'b00, phase_p, 1'b0});
    end else begin
      tri_w = $signed({2'b00, phase_p, 1'b0}) - 19'sd32768;
    end

    unique case (tbwg_pkg::wave_kind_t'(kind_r))
      tbwg_pkg::WAVE_SINE: begin
        value_w = quad[1] ? -$signed({1'b0, rom_data}) : $signed({1'b0, rom_data});
      end
      tbwg_pkg::WAVE_TRI: begin
        value_w = (tri_w > 19'sd32767) ? 16'sd32767 : tbwg_pkg::VAL_W'(tri_w);
      end
      tbwg_pkg::WAVE_SAW: begin
        value_w = $signed(phase_p);
      end
      tbwg_pkg::WAVE_SQUARE: begin
        value_w = ({idx_r, 1'b0} < len_r) ? 16'sd32767 : -16'sd32768;
      end
      default: value_w = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (val_ld) begin
      value_r <= value_w;
    end
  end

  // --------------------------------------------------------------------------
  // Shared multiplier: amplitude * value, then |volt| * codes_per_volt
  // --------------------------------------------------------------------------
  logic signed [tbwg_pkg::MUL_A_W-1:0] mul_a;
  logic signed [tbwg_pkg::MUL_B_W-1:0] mul_b;
  logic signed [tbwg_pkg::MUL_P_W-1:0] mul_p;
  logic [15:0]                         mag_r;
  logic                                neg_r;

  always_comb begin
    if (mul_sel_code) begin
      mul_a = $signed({1'b0, cpv_r});
      mul_b = $signed({2'b00, mag_r});
    end else begin
      mul_a = tbwg_pkg::MUL_A_W'(value_r);
      mul_b = amp_r;
    end
  end

  tbwg_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (mul_p)
  );

  // --------------------------------------------------------------------------
  // Voltage: round the product to 1/4096 V, add offset, clamp to +/-8 V
  // --------------------------------------------------------------------------
  logic signed [tbwg_pkg::MUL_P_W-1:0] prod_rnd;
  logic signed [21:0]                  scaled;
  logic signed [21:0]                  volt;
  logic signed [21:0]                  volt_c;
  logic [21:0]                         volt_abs;

  always_comb begin
    prod_rnd = mul_p + tbwg_pkg::MUL_P_W'(16384);
    scaled   = 22'(prod_rnd >>> 15);
    volt     = 22'(off_r) + scaled;
    if (volt > 22'sd32768) begin
      volt_c = 22'sd32768;
    end else if (volt < -22'sd32768) begin
      volt_c = -22'sd32768;
    end else begin
      volt_c = volt;
    end
    volt_abs = volt_c[21] ? 22'(-volt_c) : 22'(volt_c);
  end

  always_ff @(posedge clk) begin
    if (volt_ld) begin
      mag_r <= volt_abs[15:0];
      neg_r <= volt_c[21];
    end
  end

  // --------------------------------------------------------------------------
  // DAC code: zero code plus signed delta, clamp to the code range
  // --------------------------------------------------------------------------
  logic [11:0]        delta;
  logic signed [13:0] code_s;
  logic [11:0]        code_w;

  always_comb begin
    delta  = mul_p[39:28];
    code_s = neg_r ? ($signed({2'b00, zero_r}) - $signed({2'b00, delta}))
                   : ($signed({2'b00, zero_r}) + $signed({2'b00, delta}));
    if (code_s < 14'sd0) begin
      code_w = '0;
    end else if (code_s > 14'sd4095) begin
      code_w = 12'd4095;
    end else begin
      code_w = code_s[11:0];
    end
  end

  // --------------------------------------------------------------------------
  // Output register: hold the result until the sink takes it
  // --------------------------------------------------------------------------
  logic [tbwg_pkg::CODE_W-1:0] dac_code_r;
  logic [tbwg_pkg::CH_W-1:0]   channel_r;
  logic [tbwg_pkg::IDX_W-1:0]  sample_index_r;
  logic                        period_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      dac_code_r     <= code_w;
      channel_r      <= chan_r;
      sample_index_r <= idx_r;
      period_end_r   <= wrap_r;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.dac_code     = dac_code_r;
  assign out_chan.channel      = channel_r;
  assign out_chan.sample_index = sample_index_r;
  assign out_chan.period_end   = period_end_r;

endmodule

// ----- src/tbwg_checker.sv -----
// ----------------------------------------------------------------------------
// tbwg_checker: port-level checks for the table waveform generator
// Watches the channel handshakes of the top level over time.
// ----------------------------------------------------------------------------
module tbwg_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [tbwg_pkg::CODE_W-1:0] dac_code,
  input logic [tbwg_pkg::IDX_W-1:0]  sample_index
);

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // Busy while an accepted tick is being worked on
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second tick taken while the sequencer is busy");

  // A result never appears right after a tick is taken
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared without the processing latency");

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(dac_code) && $stable(sample_index))
    else $error("stalled result changed or dropped");

endmodule

bind table_waveform_generator_top tbwg_checker u_tbwg_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .dac_code     (out_chan.dac_code),
  .sample_index (out_chan.sample_index)
);

// ----- dv/table_waveform_generator_top_tb.sv -----
// ----------------------------------------------------------------------------
// table_waveform_generator_top_tb: self-checking bench for the waveform block
// Sends sample ticks and register writes over the valid/ready channels. A
// fixed-point model inside the bench predicts every DAC code. The bench
// compares each output transfer, field by field, with the oldest
// prediction. Random gaps on the tick side and random stalls on the result
// side land on every step of the block's sequencer.
// ----------------------------------------------------------------------------
module table_waveform_generator_top_tb;
  import tbwg_pkg::*;

  localparam int SINE_DEPTH    = SINE_ROM_DEPTH_DEF;
  localparam int CFG_NUM_REGS  = 8;
  localparam int CFG_IDX_MAX   = (1 << CFG_IDX_W) - 1;
  localparam int TICK_TARGET   = 1800;
  localparam int SETTLE_CYCLES = 30;           // margin beyond the block's processing time
  localparam int HALF_TURN     = 32768;        // phase 0.5 in 0.16, also -1.0 in Q1.15
  localparam int QUARTER_TURN  = 16384;
  localparam int Q15_MAX       = 32767;
  localparam int CODE_MAX      = (1 << CODE_W) - 1;
  localparam int AMP_MAX       = 131071;
  localparam int AMP_MIN       = -131072;
  localparam int REP_MAX       = (1 << REP_W) - 1;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [CH_W-1:0]   chan;
    logic [IDX_W-1:0]  idx;
    logic              wrap;
  } dac_result_t;

  typedef struct {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } cfg_write_t;

  // --------------------------------------------------------------------------
  // Predictor of the DAC code stream: register copy, table position, hold
  // counter and the queue of codes still owed by the block.
  // --------------------------------------------------------------------------
  class waveform_model;
    wave_kind_t              kind;
    logic [LEN_W-1:0]        tab_len;
    logic [REP_W-1:0]        rep_cnt;
    logic signed [AMP_W-1:0] amp;
    logic signed [AMP_W-1:0] offs;
    logic [CPV_W-1:0]        cpv;
    logic [CODE_W-1:0]       zero;
    logic [CH_W-1:0]         chan;
    logic [IDX_W-1:0]        pos;
    logic [REP_W-1:0]        hold_left;
    int                      quarter_sine[SINE_DEPTH+1];
    dac_result_t             code_queue[$];
    int                      error_count;

    // Taylor series of sin(pi/2 * k/D) in Q30, rounded to Q15
    function int sine_q15(int k);
      u64_t   x;
      u64_t   x2;
      u64_t   term;
      longint sum;
      x    = (u64_t'(k) * HALF_PI_Q30) / u64_t'(SINE_DEPTH);
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 5; n++) begin
        term = ((term * x2) >> 30) / u64_t'(2 * n * (2 * n + 1));
        sum  = (n % 2 == 1) ? sum - longint'(term) : sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      sum = (sum + QUARTER_TURN) >>> 15;
      return (sum > Q15_MAX) ? Q15_MAX : int'(sum);
    endfunction

    function void restore();
      kind        = wave_kind_t'(RST_KIND);
      tab_len     = RST_LEN;
      rep_cnt     = RST_REP;
      amp         = RST_AMP;
      offs        = RST_OFF;
      cpv         = RST_CPV;
      zero        = RST_ZERO;
      chan        = RST_CHAN;
      pos         = '0;
      hold_left   = REP_W'(1);
      error_count = 0;
      code_queue.delete();
      for (int k = 0; k <= SINE_DEPTH; k++) quarter_sine[k] = sine_q15(k);
    endfunction

    // Unused indexes drop out; data is cut to the register width
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_KIND:    kind    = wave_kind_t'(data[KIND_W-1:0]);
        REG_LENGTH:  tab_len = data[LEN_W-1:0];
        REG_REPEAT:  rep_cnt = data[REP_W-1:0];
        REG_AMP:     amp     = signed'(data[AMP_W-1:0]);
        REG_OFFSET:  offs    = signed'(data[AMP_W-1:0]);
        REG_CPV:     cpv     = data[CPV_W-1:0];
        REG_ZERO:    zero    = data[CODE_W-1:0];
        REG_CHANNEL: chan    = data[CH_W-1:0];
        default: ;
      endcase
    endfunction

    // Q1.15 wave value at table position idx of a period of len samples
    function int shape(int idx, int len);
      int p;
      int q;
      int f;
      int k;
      int v;
      p = (idx << 16) / len;
      case (kind)
        WAVE_SINE: begin
          q = (p >> 14) & 3;
          f = p % QUARTER_TURN;
          k = ((((q & 1) != 0) ? QUARTER_TURN - f : f) * SINE_DEPTH) >> 14;
          v = quarter_sine[k];
          if ((q & 2) != 0) v = -v;
        end
        WAVE_TRI: begin
          v = (p < HALF_TURN) ? 2 * p - HALF_TURN : 3 * HALF_TURN - 2 * p;
          if (v > Q15_MAX) v = Q15_MAX;
        end
        WAVE_SAW: v = (p < HALF_TURN) ? p : p - 2 * HALF_TURN;
        default:  v = (2 * idx < len) ? Q15_MAX : -HALF_TURN;
      endcase
      return v;
    endfunction

    // Scale, offset, clamp to +/-8 V, convert to a clamped DAC code
    function logic [CODE_W-1:0] to_dac(int value);
      longint volt;
      longint delta;
      longint code;
      u64_t   mag;
      volt = longint'(offs) + ((longint'(amp) * value + QUARTER_TURN) >>> 15);
      if (volt > VOLT_LIMIT) volt = VOLT_LIMIT;
      else if (volt < -VOLT_LIMIT) volt = -VOLT_LIMIT;
      mag   = u64_t'((volt < 0) ? -volt : volt) * u64_t'(cpv);
      delta = longint'(mag >> 28);
      if (volt < 0) delta = -delta;
      code = longint'(zero) + delta;
      if (code < 0) code = 0;
      if (code > CODE_MAX) code = CODE_MAX;
      return code[CODE_W-1:0];
    endfunction

    function void note_tick(logic restart);
      int          len;
      int          hold;
      int          idx;
      int          nxt;
      dac_result_t r;
      len = (tab_len < LEN_MIN) ? int'(LEN_MIN) : int'(tab_len);
      if (len > int'(LEN_CAP)) len = int'(LEN_CAP);
      hold = (rep_cnt == '0) ? 1 : int'(rep_cnt);
      if (restart) begin
        pos       = '0;
        hold_left = REP_W'(hold);
      end
      // a position left over from a longer table restarts the period
      if (int'(pos) >= len) pos = '0;
      idx    = int'(pos);
      r.code = to_dac(shape(idx, len));
      r.chan = chan;
      r.idx  = IDX_W'(idx);
      r.wrap = 1'b0;
      // a hold count above repeat_count still runs down to one
      if (hold_left > 1) begin
        hold_left = hold_left - 1'b1;
      end else begin
        hold_left = REP_W'(hold);
        nxt       = idx + 1;
        if (nxt >= len) begin
          nxt    = 0;
          r.wrap = 1'b1;
        end
        pos = IDX_W'(nxt);
      end
      code_queue.push_back(r);
    endfunction

    function void check_code(dac_result_t seen);
      dac_result_t want;
      if (code_queue.size() == 0) begin
        error_count++;
        $display("%0t: output transfer with nothing owed: code=%0d ch=%0d idx=%0d end=%0b",
                 $time, seen.code, seen.chan, seen.idx, seen.wrap);
        return;
      end
      want = code_queue.pop_front();
      if (seen !== want) begin
        error_count++;
        $display("%0t: mismatch, expected code=%0d ch=%0d idx=%0d end=%0b",
                 $time, want.code, want.chan, want.idx, want.wrap);
        $display("%0t:           actual   code=%0d ch=%0d idx=%0d end=%0b",
                 $time, seen.code, seen.chan, seen.idx, seen.wrap);
      end
    endfunction

    function int pending();
      return code_queue.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, channels, block under test
  // --------------------------------------------------------------------------
  logic          clk;
  logic          rst_n;
  bit            calm;           // suppress gaps and stalls for this phase
  int            stall_left;
  int            ticks_sent;
  waveform_model gen_model;

  tbwg_in_if  in_chan ();
  tbwg_out_if out_chan ();
  tbwg_cfg_if cfg_chan ();

  table_waveform_generator_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Idle length: mostly a few cycles, now and then a long one
  function automatic int idle_len();
    return ($urandom_range(0, 9) < 8) ? int'($urandom_range(1, 4)) : int'($urandom_range(12, 64));
  endfunction

  function automatic cfg_write_t reg_write(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] data);
    cfg_write_t w;
    w.idx  = idx;
    w.data = data;
    return w;
  endfunction

  // Random value for one register, extremes included; half the time put
  // noise above the register width so the masking gets exercised
  function automatic logic [CFG_DATA_W-1:0] reg_value(cfg_reg_t r);
    int                    roll;
    int                    width;
    logic [CFG_DATA_W-1:0] v;
    logic [CFG_DATA_W-1:0] keep;
    roll = $urandom_range(0, 9);
    case (r)
      REG_KIND: begin
        width = KIND_W;
        v     = CFG_DATA_W'($urandom_range(0, 3));
      end
      REG_LENGTH: begin
        width = LEN_W;
        if (roll < 7)       v = CFG_DATA_W'($urandom_range(2, 80));
        else if (roll == 7) v = CFG_DATA_W'($urandom_range(0, 1));
        else if (roll == 8) v = $urandom_range(0, 1) ? CFG_DATA_W'(4096) : CFG_DATA_W'(8191);
        else                v = CFG_DATA_W'($urandom_range(0, 8191));
      end
      REG_REPEAT: begin
        width = REP_W;
        if (roll < 7)       v = CFG_DATA_W'($urandom_range(1, 4));
        else if (roll == 7) v = '0;
        else if (roll == 8) v = CFG_DATA_W'($urandom_range(5, 40));
        else                v = CFG_DATA_W'(REP_MAX);
      end
      REG_AMP: begin
        width = AMP_W;
        if (roll < 4)       v = CFG_DATA_W'($urandom);
        else if (roll == 4) v = $urandom_range(0, 1) ? CFG_DATA_W'(AMP_MAX) : CFG_DATA_W'(AMP_MIN);
        else                v = CFG_DATA_W'(int'($urandom_range(0, 16383)) - 8192);
      end
      REG_OFFSET: begin
        width = AMP_W;
        if (roll < 3)       v = CFG_DATA_W'($urandom);
        else if (roll == 3) v = $urandom_range(0, 1) ? CFG_DATA_W'(AMP_MAX) : CFG_DATA_W'(AMP_MIN);
        else                v = CFG_DATA_W'(int'($urandom_range(0, 8191)) - 4096);
      end
      REG_CPV: begin
        width = CPV_W;
        if (roll < 3)       v = CFG_DATA_W'($urandom);
        else if (roll == 3) v = $urandom_range(0, 1) ? '1 : '0;
        else                v = RST_CPV + CFG_DATA_W'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
      end
      REG_ZERO: begin
        width = CODE_W;
        if (roll == 0)      v = '0;
        else if (roll == 1) v = CFG_DATA_W'(CODE_MAX);
        else                v = CFG_DATA_W'($urandom_range(0, CODE_MAX));
      end
      default: begin
        width = CH_W;
        v     = CFG_DATA_W'($urandom_range(0, 3));
      end
    endcase
    keep = (width >= CFG_DATA_W) ? '1 : CFG_DATA_W'((1 << width) - 1);
    if ($urandom_range(0, 1) == 1) v = (v & keep) | (CFG_DATA_W'($urandom) & ~keep);
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Wait until every owed code has come back; the first edge lets the
  // monitor log a tick taken in the current step
  task automatic drain();
    @(posedge clk);
    while (gen_model.pending() != 0) @(posedge clk);
  endtask

  // Write a list of registers back to back, then drop valid
  task automatic program_regs(input cfg_write_t writes[$]);
    foreach (writes[i]) begin
      cfg_chan.valid <= 1'b1;
      cfg_chan.index <= writes[i].idx;
      cfg_chan.data  <= writes[i].data;
      @(posedge clk);
      while (!cfg_chan.ready) @(posedge clk);
    end
    cfg_chan.valid <= 1'b0;
  endtask

  // One tick: optional gap, then hold valid until the transfer. Valid is
  // left high so a following tick with no gap keeps it up without a glitch.
  task automatic send_tick(input logic rs);
    int gap;
    gap = (calm || $urandom_range(0, 1) == 0) ? 0 : idle_len();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.restart <= rs;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    ticks_sent++;
  endtask

  // A run of ticks; restart_pct sets how often a tick restarts the table
  task automatic tick_batch(input int n, input int restart_pct, input bit lead_restart);
    for (int i = 0; i < n; i++) begin
      send_tick((i == 0 && lead_restart) || ($urandom_range(0, 99) < restart_pct));
    end
    in_chan.valid <= 1'b0;
    drain();
  endtask

  // Result side: stall at random, short mostly, long now and then
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      stall_left     <= 0;
    end else if (stall_left > 0) begin
      out_chan.ready <= 1'b0;
      stall_left     <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_chan.ready <= 1'b0;
      stall_left     <= idle_len() - 1;
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  // Monitor: log register writes and ticks, check every output transfer
  always @(posedge clk) begin
    dac_result_t seen;
    if (rst_n) begin
      if (cfg_chan.valid && cfg_chan.ready) gen_model.write_reg(cfg_chan.index, cfg_chan.data);
      if (out_chan.valid && out_chan.ready) begin
        seen = {out_chan.dac_code, out_chan.channel, out_chan.sample_index, out_chan.period_end};
        gen_model.check_code(seen);
      end
      if (in_chan.valid && in_chan.ready) gen_model.note_tick(in_chan.restart);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    cfg_write_t writes[$];
    gen_model = new;
    gen_model.restore();
    rst_n           <= 1'b0;
    in_chan.valid   <= 1'b0;
    in_chan.restart <= 1'b0;
    cfg_chan.valid  <= 1'b0;
    cfg_chan.index  <= '0;
    cfg_chan.data   <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: plain tick, then a restart
    tick_batch(1, 0, 1'b0);
    tick_batch(1, 0, 1'b1);

    // Triangle on a too-short table at full positive amplitude
    writes = '{reg_write(REG_KIND, CFG_DATA_W'(WAVE_TRI)), reg_write(REG_LENGTH, '0),
               reg_write(REG_AMP, CFG_DATA_W'(AMP_MAX))};
    program_regs(writes);
    tick_batch(2, 0, 1'b0);

    // Sawtooth on an over-long table, full negative amplitude, steepest
    // conversion, zero code at the bottom
    writes = '{reg_write(REG_KIND, CFG_DATA_W'(WAVE_SAW)),
               reg_write(REG_LENGTH, CFG_DATA_W'(8191)),
               reg_write(REG_AMP, CFG_DATA_W'(AMP_MIN)), reg_write(REG_CPV, '1),
               reg_write(REG_ZERO, '0)};
    program_regs(writes);
    tick_batch(2, 0, 1'b1);

    // Square over an odd table with a zero repeat count, top offset, top
    // zero code, last channel; run through a wrap
    writes = '{reg_write(REG_KIND, CFG_DATA_W'(WAVE_SQUARE)),
               reg_write(REG_LENGTH, CFG_DATA_W'(3)),
               reg_write(REG_REPEAT, '0), reg_write(REG_OFFSET, CFG_DATA_W'(AMP_MAX)),
               reg_write(REG_ZERO, CFG_DATA_W'(CODE_MAX)), reg_write(REG_CHANNEL, CFG_DATA_W'(3)),
               reg_write(REG_AMP, CFG_DATA_W'(RST_AMP)), reg_write(REG_CPV, RST_CPV)};
    program_regs(writes);
    tick_batch(4, 0, 1'b1);

    // Advance the position, then shrink the table under it
    writes = '{reg_write(REG_KIND, CFG_DATA_W'(WAVE_SAW)),
               reg_write(REG_LENGTH, CFG_DATA_W'(64)),
               reg_write(REG_OFFSET, '0), reg_write(REG_ZERO, CFG_DATA_W'(RST_ZERO))};
    program_regs(writes);
    tick_batch(3, 0, 1'b1);
    writes = '{reg_write(REG_LENGTH, CFG_DATA_W'(2))};
    program_regs(writes);
    tick_batch(1, 0, 1'b0);

    // Load the largest hold count, then lower repeat_count below what is
    // left; bottom offset and a zero conversion slope
    writes = '{reg_write(REG_REPEAT, CFG_DATA_W'(REP_MAX)),
               reg_write(REG_OFFSET, CFG_DATA_W'(AMP_MIN)), reg_write(REG_CPV, '0)};
    program_regs(writes);
    tick_batch(2, 0, 1'b1);
    writes = '{reg_write(REG_REPEAT, CFG_DATA_W'(2))};
    program_regs(writes);
    tick_batch(2, 0, 1'b0);

    // Writes to unused indexes and data wider than the register
    writes = '{reg_write(CFG_IDX_W'(CFG_NUM_REGS), '1), reg_write(CFG_IDX_W'(CFG_IDX_MAX), '1),
               reg_write(REG_KIND, '1), reg_write(REG_CHANNEL, CFG_DATA_W'('hFFFFFE)),
               reg_write(REG_LENGTH, CFG_DATA_W'('hFFE004)), reg_write(REG_CPV, RST_CPV)};
    program_regs(writes);
    tick_batch(2, 0, 1'b1);

    // Sine on the largest table at full amplitude
    writes = '{reg_write(REG_KIND, CFG_DATA_W'(WAVE_SINE)),
               reg_write(REG_LENGTH, CFG_DATA_W'(4096)),
               reg_write(REG_AMP, CFG_DATA_W'(AMP_MAX)), reg_write(REG_OFFSET, '0),
               reg_write(REG_REPEAT, CFG_DATA_W'(1))};
    program_regs(writes);
    tick_batch(3, 0, 1'b1);

    // Random phases: rewrite a random subset of registers while idle, then
    // a run of ticks. Most runs restart rarely and walk the table; some
    // restart often to break the hold and wrap sequence.
    while (ticks_sent < TICK_TARGET) begin
      calm = ($urandom_range(0, 4) == 0);
      writes.delete();
      for (int r = 0; r < CFG_NUM_REGS; r++) begin
        if ($urandom_range(0, 2) == 0) begin
          writes.push_back(reg_write(CFG_IDX_W'(r), reg_value(cfg_reg_t'(r))));
        end
      end
      if ($urandom_range(0, 9) == 0) begin
        writes.push_back(reg_write(CFG_IDX_W'($urandom_range(CFG_NUM_REGS, CFG_IDX_MAX)),
                                   CFG_DATA_W'($urandom)));
      end
      writes.shuffle();
      program_regs(writes);
      tick_batch($urandom_range(8, 60), ($urandom_range(0, 5) == 0) ? 40 : 3,
                 1'($urandom_range(0, 1)));
    end

    // Let any stray output show up before the verdict
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (gen_model.error_count == 0 && gen_model.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #40_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
